/* hdl/positional_insert_delete_list_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the positional insert/delete list
// Concurrent assertion wrappers clocked on clk, reset on rst_n. The check
// bodies are empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_INSERT_DELETE_LIST_ASSERT_SVH
`define POSITIONAL_INSERT_DELETE_LIST_ASSERT_SVH

`ifndef SYNTHESIS

// check that is switched off while reset is asserted
`define PILD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that also holds during reset
`define PILD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define PILD_ASSERT(lbl, prop, msg)
`define PILD_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

/* hdl/pild_pkg.sv */
// ----------------------------------------------------------------------------
// pild_pkg
// Sizes, codes and shared types of the positional insert/delete list.
// ----------------------------------------------------------------------------
`default_nettype none

package pild_pkg;

    // list geometry
    localparam int DEPTH     = 64;
    localparam int WORD_BITS = 32;

    // item field widths
    localparam int ACTION_BITS = 3;
    localparam int POS_BITS    = 7;
    localparam int VALUE_BITS  = 32;
    localparam int STATUS_BITS = 2;
    localparam int LEN_BITS    = 7;

    // derived widths
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam int IDX_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMP_BITS = (POS_BITS > CNT_BITS) ? POS_BITS : CNT_BITS;

    // read select: groups of GS cells, then one of NG group registers
    localparam int GS_BITS  = (IDX_BITS < 3) ? IDX_BITS : 3;
    localparam int HI_BITS  = (IDX_BITS - GS_BITS > 1) ? IDX_BITS - GS_BITS : 1;
    localparam int SEL_BITS = GS_BITS + HI_BITS;
    localparam int GS       = 1 << GS_BITS;
    localparam int NG       = 1 << HI_BITS;

    typedef enum logic [ACTION_BITS-1:0] {
        ACT_APPEND = 3'd0,
        ACT_INSERT = 3'd1,
        ACT_READ   = 3'd2,
        ACT_WRITE  = 3'd3,
        ACT_DELETE = 3'd4
    } action_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // broadcast to every cell in the row
    typedef struct packed {
        logic                  go;
        action_t               op;
        logic [CMP_BITS-1:0]   pos;
        logic [CMP_BITS-1:0]   cnt;
        logic [WORD_BITS-1:0]  val;
    } cell_ctl_t;

endpackage

`default_nettype wire

/* hdl/pild_cmd_if.sv */
// ----------------------------------------------------------------------------
// pild_cmd_if
// Command channel: valid/ready handshake with action, position and value.
// ----------------------------------------------------------------------------
`default_nettype none

interface pild_cmd_if;
    logic                             valid;
    logic                             ready;
    logic [pild_pkg::ACTION_BITS-1:0] action;
    logic [pild_pkg::POS_BITS-1:0]    position;
    logic [pild_pkg::VALUE_BITS-1:0]  value;

    modport source (output valid, output action, output position, output value,
                    input ready);
    modport sink   (input valid, input action, input position, input value,
                    output ready);
endinterface

`default_nettype wire

/* hdl/pild_rsp_if.sv */
// ----------------------------------------------------------------------------
// pild_rsp_if
// Response channel: valid/ready handshake with status, read word and length.
// ----------------------------------------------------------------------------
`default_nettype none

interface pild_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [pild_pkg::STATUS_BITS-1:0] status;
    logic [pild_pkg::VALUE_BITS-1:0]  read_value;
    logic [pild_pkg::LEN_BITS-1:0]    length;

    modport source (output valid, output status, output read_value, output length,
                    input ready);
    modport sink   (input valid, input status, input read_value, input length,
                    output ready);
endinterface

`default_nettype wire

/* hdl/positional_insert_delete_list.sv */
// ----------------------------------------------------------------------------
// positional_insert_delete_list
// Ordered list of words kept in a row of shifting cells, with positional
// append, insert, read, overwrite and delete.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one item per command: action, position and value. rsp returns
//   one item per command: status, the word read or removed, and the length.
//   Both channels transfer when valid and ready are high at a clock edge.
//   At acceptance every cell loads, shifts or holds in one step and the read
//   word of the old contents is picked into group registers; in the select
//   state the group is chosen and the response register is loaded when free.
//   cmd.ready is high only in the idle state, so one command is in flight at
//   a time: a new command waits until the last one has loaded its response.
//   The response register parts the channels: a new command is taken while a
//   response still waits; its own response then waits in the select stage
//   until rsp.ready frees the register.
//   Reset clears the length and the control state; the cell contents are not
//   cleared and are only read below the length.
// ----------------------------------------------------------------------------
`default_nettype none

`include "positional_insert_delete_list_assert.svh"

module positional_insert_delete_list (
    input  wire logic clk,
    input  wire logic rst_n,
    pild_cmd_if.sink  cmd,
    pild_rsp_if.source rsp
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SEL  = 2'b10
    } state_t;

    state_t                             state_reg;
    state_t                             state_next;
    logic [pild_pkg::CNT_BITS-1:0]      count_reg;
    logic [pild_pkg::CNT_BITS-1:0]      count_next;
    logic [pild_pkg::CNT_BITS-1:0]      cnt_upd;
    logic                               accept;
    logic                               do_op;
    logic                               rd_en;
    logic                               full;
    pild_pkg::action_t                  act;
    pild_pkg::status_t                  status_d;
    logic [pild_pkg::CMP_BITS-1:0]      pos_c;
    logic [pild_pkg::CMP_BITS-1:0]      cnt_c;
    pild_pkg::cell_ctl_t                cell_ctl;
    logic [pild_pkg::WORD_BITS-1:0]     cell_word [pild_pkg::DEPTH];
    logic [pild_pkg::WORD_BITS-1:0]     sel_word;
    logic                               rsp_load;

    // select stage payload
    pild_pkg::status_t                  st_status_reg;
    logic                               st_rd_en_reg;
    logic [pild_pkg::LEN_BITS-1:0]      st_len_reg;

    // response register
    logic                               rsp_valid_reg;
    pild_pkg::status_t                  rsp_status_reg;
    logic [pild_pkg::VALUE_BITS-1:0]    rsp_value_reg;
    logic [pild_pkg::LEN_BITS-1:0]      rsp_len_reg;

    assign cmd.ready = (state_reg == S_IDLE);
    assign accept    = cmd.valid && cmd.ready;
    assign rsp_load  = (state_reg == S_SEL) && (!rsp_valid_reg || rsp.ready);

    assign act   = pild_pkg::action_t'(cmd.action);
    assign pos_c = pild_pkg::CMP_BITS'(cmd.position);
    assign cnt_c = pild_pkg::CMP_BITS'(count_reg);
    assign full  = (count_reg == pild_pkg::CNT_BITS'(pild_pkg::DEPTH));

    // command decode and range checks
    always_comb
    begin
        status_d = pild_pkg::ST_DONE;
        do_op    = 1'b0;
        rd_en    = 1'b0;
        cnt_upd  = count_reg;
        unique case (act) inside
            pild_pkg::ACT_APPEND:
            begin
                if (full)
                    status_d = pild_pkg::ST_FULL;
                else
                begin
                    do_op   = 1'b1;
                    cnt_upd = count_reg + pild_pkg::CNT_BITS'(1);
                end
            end
            pild_pkg::ACT_INSERT:
            begin
                if (pos_c > cnt_c)
                    status_d = pild_pkg::ST_RANGE;
                else if (full)
                    status_d = pild_pkg::ST_FULL;
                else
                begin
                    do_op   = 1'b1;
                    cnt_upd = count_reg + pild_pkg::CNT_BITS'(1);
                end
            end
            pild_pkg::ACT_READ, pild_pkg::ACT_WRITE, pild_pkg::ACT_DELETE:
            begin
                if (pos_c >= cnt_c)
                    status_d = pild_pkg::ST_RANGE;
                else
                begin
                    do_op = 1'b1;
                    rd_en = (act != pild_pkg::ACT_WRITE);
                    if (act == pild_pkg::ACT_DELETE)
                        cnt_upd = count_reg - pild_pkg::CNT_BITS'(1);
                end
            end
            default:
            begin
                status_d = pild_pkg::ST_RANGE;
            end
        endcase
    end

    assign count_next = (accept && do_op) ? cnt_upd : count_reg;

    // broadcast to the row
    always_comb
    begin
        cell_ctl.go  = accept && do_op;
        cell_ctl.op  = act;
        cell_ctl.pos = pos_c;
        cell_ctl.cnt = cnt_c;
        cell_ctl.val = pild_pkg::WORD_BITS'(cmd.value);
    end

    // row of cells; the end cells see themselves as the missing neighbor
    for (genvar i = 0; i < pild_pkg::DEPTH; i++)
    begin : g_cell
        logic [pild_pkg::WORD_BITS-1:0] low_w;
        logic [pild_pkg::WORD_BITS-1:0] high_w;

        if (i == 0)
        begin : g_lo_end
            assign low_w = cell_word[i];
        end
        else
        begin : g_lo
            assign low_w = cell_word[i-1];
        end

        if (i == pild_pkg::DEPTH - 1)
        begin : g_hi_end
            assign high_w = cell_word[i];
        end
        else
        begin : g_hi
            assign high_w = cell_word[i+1];
        end

        pild_cell u_cell (
            .clk       (clk),
            .idx       (pild_pkg::IDX_BITS'(i)),
            .ctl       (cell_ctl),
            .low_word  (low_w),
            .high_word (high_w),
            .word      (cell_word[i])
        );
    end

    // read select over the old contents
    pild_sel u_sel (
        .clk   (clk),
        .cap   (accept),
        .pos   (pos_c),
        .words (cell_word),
        .word  (sel_word)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_SEL;
            end
            S_SEL:
            begin
                if (rsp_load)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (rsp_load)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // select stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            st_status_reg <= status_d;
            st_rd_en_reg  <= rd_en;
            st_len_reg    <= pild_pkg::LEN_BITS'(count_next);
        end
    end

    // response payload
    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            rsp_status_reg <= st_status_reg;
            rsp_value_reg  <= st_rd_en_reg ? pild_pkg::VALUE_BITS'(sel_word) : '0;
            rsp_len_reg    <= st_len_reg;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.status     = rsp_status_reg;
    assign rsp.read_value = rsp_value_reg;
    assign rsp.length     = rsp_len_reg;

    // checks
    `PILD_ASSERT_ALWAYS(a_count_bound, !rst_n || (count_reg <= pild_pkg::CNT_BITS'(pild_pkg::DEPTH)), "length above depth")
    `PILD_ASSERT(a_accept_to_sel, accept |=> (state_reg == S_SEL), "accepted item not in select stage")
    `PILD_ASSERT(a_count_only_on_accept, !accept |=> $stable(count_reg), "length changed without an item")
    `PILD_ASSERT(a_rsp_from_sel, $rose(rsp_valid_reg) |-> $past(state_reg == S_SEL), "response without select stage")

endmodule

`default_nettype wire

/* hdl/pild_cell.sv */
// ----------------------------------------------------------------------------
// pild_cell
// One list slot. Holds a word, loads the command value, or takes the word
// of its lower or upper neighbor when the list shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module pild_cell (
    input  wire logic                           clk,
    input  wire logic [pild_pkg::IDX_BITS-1:0]  idx,
    input  wire pild_pkg::cell_ctl_t            ctl,
    input  wire logic [pild_pkg::WORD_BITS-1:0] low_word,
    input  wire logic [pild_pkg::WORD_BITS-1:0] high_word,
    output logic      [pild_pkg::WORD_BITS-1:0] word
);

    logic [pild_pkg::WORD_BITS-1:0] word_reg;
    logic [pild_pkg::WORD_BITS-1:0] word_next;
    logic [pild_pkg::CMP_BITS-1:0]  my_pos;

    assign my_pos = pild_pkg::CMP_BITS'(idx);

    // slot update from the broadcast command
    always_comb
    begin
        word_next = word_reg;
        if (ctl.go)
        begin
            unique case (ctl.op)
                pild_pkg::ACT_APPEND:
                begin
                    if (my_pos == ctl.cnt)
                        word_next = ctl.val;
                end
                pild_pkg::ACT_INSERT:
                begin
                    if (my_pos == ctl.pos)
                        word_next = ctl.val;
                    else if (my_pos > ctl.pos)
                        word_next = low_word;
                end
                pild_pkg::ACT_WRITE:
                begin
                    if (my_pos == ctl.pos)
                        word_next = ctl.val;
                end
                pild_pkg::ACT_DELETE:
                begin
                    if (my_pos >= ctl.pos)
                        word_next = high_word;
                end
                default:
                begin
                    word_next = word_reg;
                end
            endcase
        end
    end

    // payload register, no reset
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

`default_nettype wire

/* hdl/pild_sel.sv */
// ----------------------------------------------------------------------------
// pild_sel
// Two-level read select over the cell row. The first level picks one word
// per group into registers at capture; the second picks the group.
// ----------------------------------------------------------------------------
`default_nettype none

module pild_sel (
    input  wire logic                           clk,
    input  wire logic                           cap,
    input  wire logic [pild_pkg::CMP_BITS-1:0]  pos,
    input  wire logic [pild_pkg::WORD_BITS-1:0] words [pild_pkg::DEPTH],
    output logic      [pild_pkg::WORD_BITS-1:0] word
);

    logic [pild_pkg::WORD_BITS-1:0] pad_word [pild_pkg::NG][pild_pkg::GS];
    logic [pild_pkg::WORD_BITS-1:0] grp_reg  [pild_pkg::NG];
    logic [pild_pkg::HI_BITS-1:0]   hi_reg;
    logic [pild_pkg::SEL_BITS-1:0]  sidx;

    assign sidx = pild_pkg::SEL_BITS'(pos);

    // pad the row out to whole groups
    for (genvar g = 0; g < pild_pkg::NG; g++)
    begin : g_grp
        for (genvar k = 0; k < pild_pkg::GS; k++)
        begin : g_lane
            if (g * pild_pkg::GS + k < pild_pkg::DEPTH)
            begin : g_real
                assign pad_word[g][k] = words[g * pild_pkg::GS + k];
            end
            else
            begin : g_pad
                assign pad_word[g][k] = '0;
            end
        end
    end

    // first level, captured from the row before it updates
    always_ff @(posedge clk)
    begin
        if (cap)
        begin
            for (int g = 0; g < pild_pkg::NG; g++)
                grp_reg[g] <= pad_word[g][sidx[pild_pkg::GS_BITS-1:0]];
            hi_reg <= sidx[pild_pkg::SEL_BITS-1:pild_pkg::GS_BITS];
        end
    end

    // second level
    assign word = grp_reg[hi_reg];

endmodule

`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - positional insert/delete list testbench
// Drives list commands over the valid/ready command channel and checks every
// response item against the directed table's expected item or a testbench shadow list.
// A short directed table covers the empty, boundary, full and bad-action
// cases; random phases then sweep the list between empty and full under
// several idling patterns and one long response hold-off.
// ----------------------------------------------------------------------------
module tb;

    // action codes the block does not define
    localparam logic [pild_pkg::ACTION_BITS-1:0] ACT_RSVD_LO  = 3'd5;
    localparam logic [pild_pkg::ACTION_BITS-1:0] ACT_RSVD_MID = 3'd6;
    localparam logic [pild_pkg::ACTION_BITS-1:0] ACT_RSVD_HI  = 3'd7;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 400;
    localparam int PHASE_ITEMS    = 90;

    typedef struct packed {
        pild_pkg::status_t               status;
        logic [pild_pkg::VALUE_BITS-1:0] read_value;
        logic [pild_pkg::LEN_BITS-1:0]   length;
    } list_rsp_t;

    // one line of the directed table; reps > 1 repeats the row with random words
    typedef struct {
        logic [pild_pkg::ACTION_BITS-1:0] act;
        logic [pild_pkg::POS_BITS-1:0]    pos;
        logic [pild_pkg::VALUE_BITS-1:0]  val;
        int                               reps;
        bit                               typed;
        list_rsp_t                        want;
    } plan_row_t;

    logic clk;
    logic rst_n;

    pild_cmd_if cmd_ch ();
    pild_rsp_if rsp_ch ();

    positional_insert_delete_list DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    // shadow list and the responses still owed by the block
    logic [pild_pkg::WORD_BITS-1:0] shadow_words [pild_pkg::DEPTH];
    int                             shadow_len = 0;
    list_rsp_t                      awaited_rsp [$];

    plan_row_t plan [$];

    int err_count      = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int rsp_hold_left  = 0;
    int grow_pct       = 80;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // apply one command to the shadow list and return the response it owes
    function automatic list_rsp_t apply_list_op(logic [pild_pkg::ACTION_BITS-1:0] act,
                                                logic [pild_pkg::POS_BITS-1:0] pos,
                                                logic [pild_pkg::VALUE_BITS-1:0] val);
        list_rsp_t r;
        r.status     = pild_pkg::ST_DONE;
        r.read_value = '0;
        case (act)
            pild_pkg::ACT_APPEND:
            begin
                if (shadow_len >= pild_pkg::DEPTH)
                    r.status = pild_pkg::ST_FULL;
                else
                begin
                    shadow_words[shadow_len] = val;
                    shadow_len++;
                end
            end
            pild_pkg::ACT_INSERT:
            begin
                // position check wins over the full check
                if (int'(pos) > shadow_len)
                    r.status = pild_pkg::ST_RANGE;
                else if (shadow_len >= pild_pkg::DEPTH)
                    r.status = pild_pkg::ST_FULL;
                else
                begin
                    for (int i = shadow_len; i > int'(pos); i--)
                        shadow_words[i] = shadow_words[i - 1];
                    shadow_words[pos] = val;
                    shadow_len++;
                end
            end
            pild_pkg::ACT_READ, pild_pkg::ACT_WRITE, pild_pkg::ACT_DELETE:
            begin
                if (int'(pos) >= shadow_len)
                    r.status = pild_pkg::ST_RANGE;
                else if (act == pild_pkg::ACT_READ)
                    r.read_value = shadow_words[pos];
                else if (act == pild_pkg::ACT_WRITE)
                    shadow_words[pos] = val;
                else
                begin
                    r.read_value = shadow_words[pos];
                    for (int i = int'(pos); i + 1 < shadow_len; i++)
                        shadow_words[i] = shadow_words[i + 1];
                    shadow_len--;
                end
            end
            default:
                r.status = pild_pkg::ST_RANGE;
        endcase
        r.length = pild_pkg::LEN_BITS'(shadow_len);
        return r;
    endfunction

    function automatic plan_row_t known_row(logic [pild_pkg::ACTION_BITS-1:0] act,
                                            logic [pild_pkg::POS_BITS-1:0] pos,
                                            logic [pild_pkg::VALUE_BITS-1:0] val,
                                            pild_pkg::status_t st,
                                            logic [pild_pkg::VALUE_BITS-1:0] rd,
                                            logic [pild_pkg::LEN_BITS-1:0] len);
        plan_row_t row;
        row.act   = act;
        row.pos   = pos;
        row.val   = val;
        row.reps  = 1;
        row.typed = 1'b1;
        row.want  = '{st, rd, len};
        return row;
    endfunction

    function automatic plan_row_t pred_row(logic [pild_pkg::ACTION_BITS-1:0] act,
                                           logic [pild_pkg::POS_BITS-1:0] pos, int reps);
        plan_row_t row;
        row.act   = act;
        row.pos   = pos;
        row.val   = '0;
        row.reps  = reps;
        row.typed = 1'b0;
        row.want  = '0;
        return row;
    endfunction

    task automatic report_mismatch(string what, logic [pild_pkg::VALUE_BITS-1:0] got,
                                   logic [pild_pkg::VALUE_BITS-1:0] want);
        err_count++;
        $display("%0t ns: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    endtask

    // offer one command item, wait for it to be taken, log what it owes
    task automatic send_cmd(input logic [pild_pkg::ACTION_BITS-1:0] act,
                            input logic [pild_pkg::POS_BITS-1:0] pos,
                            input logic [pild_pkg::VALUE_BITS-1:0] val,
                            input bit typed, input list_rsp_t typed_rsp);
        list_rsp_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid    <= 1'b1;
        cmd_ch.action   <= act;
        cmd_ch.position <= pos;
        cmd_ch.value    <= val;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        predicted = apply_list_op(act, pos, val);
        awaited_rsp.push_back(typed ? typed_rsp : predicted);
    endtask

    // random commands that sweep the list between empty and full
    task automatic run_random(input int n);
        logic [pild_pkg::ACTION_BITS-1:0] act;
        logic [pild_pkg::POS_BITS-1:0]    pos;
        int                               k;
        int                               first_bad;
        list_rsp_t                        no_rsp;
        no_rsp = '0;
        repeat (n)
        begin
            if (shadow_len >= pild_pkg::DEPTH - 1)
                grow_pct = 20;
            else if (shadow_len <= 1)
                grow_pct = 80;
            k = $urandom_range(99);
            if (k < 4)
            begin
                case ($urandom_range(2))
                    0:       act = ACT_RSVD_LO;
                    1:       act = ACT_RSVD_MID;
                    default: act = ACT_RSVD_HI;
                endcase
            end
            else if (k < 28)
                act = pild_pkg::ACT_READ;
            else if (k < 44)
                act = pild_pkg::ACT_WRITE;
            else if ($urandom_range(99) < grow_pct)
                act = $urandom_range(1) ? pild_pkg::ACT_INSERT : pild_pkg::ACT_APPEND;
            else
                act = pild_pkg::ACT_DELETE;
            // mostly in-range positions, some past the end
            first_bad = (act == pild_pkg::ACT_INSERT) ? shadow_len + 1 : shadow_len;
            if (first_bad == 0 || $urandom_range(99) < 15)
                pos = pild_pkg::POS_BITS'($urandom_range(127, first_bad));
            else
                pos = pild_pkg::POS_BITS'($urandom_range(first_bad - 1));
            send_cmd(act, pos, $urandom, 1'b0, no_rsp);
        end
    endtask

    // response side: random stalls, or a counted hold-off when asked
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_hold_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                rsp_hold_left--;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // response checker
    always @(posedge clk)
    begin : rsp_check
        list_rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (awaited_rsp.size() == 0)
                report_mismatch("response with nothing awaited", rsp_ch.read_value, '0);
            else
            begin
                want = awaited_rsp.pop_front();
                if (rsp_ch.status !== want.status)
                    report_mismatch("status", pild_pkg::VALUE_BITS'(rsp_ch.status),
                                    pild_pkg::VALUE_BITS'(want.status));
                if (rsp_ch.read_value !== want.read_value)
                    report_mismatch("read_value", rsp_ch.read_value, want.read_value);
                if (rsp_ch.length !== want.length)
                    report_mismatch("length", pild_pkg::VALUE_BITS'(rsp_ch.length),
                                    pild_pkg::VALUE_BITS'(want.length));
            end
        end
    end

    // watchdog on cycles with no item moving on either channel
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // main sequence
    initial
    begin : main_seq
        rst_n           = 1'b0;
        cmd_ch.valid    = 1'b0;
        cmd_ch.action   = '0;
        cmd_ch.position = '0;
        cmd_ch.value    = '0;

        // empty list: every access is out of range
        plan.push_back(known_row(pild_pkg::ACT_READ,   7'd0, 32'h0,
                                 pild_pkg::ST_RANGE, 32'h0, 7'd0));
        plan.push_back(known_row(pild_pkg::ACT_DELETE, 7'd0, 32'h0,
                                 pild_pkg::ST_RANGE, 32'h0, 7'd0));
        plan.push_back(known_row(pild_pkg::ACT_WRITE,  7'd0, 32'hFFFFFFFF,
                                 pild_pkg::ST_RANGE, 32'h0, 7'd0));
        plan.push_back(known_row(pild_pkg::ACT_INSERT, 7'd1, 32'h0,
                                 pild_pkg::ST_RANGE, 32'h0, 7'd0));
        // build a short list, insert at the end position too
        plan.push_back(known_row(pild_pkg::ACT_INSERT, 7'd0, 32'hFFFFFFFF,
                                 pild_pkg::ST_DONE, 32'h0, 7'd1));
        plan.push_back(known_row(pild_pkg::ACT_READ,   7'd0, 32'h0,
                                 pild_pkg::ST_DONE, 32'hFFFFFFFF, 7'd1));
        plan.push_back(known_row(pild_pkg::ACT_APPEND, 7'd0, 32'h0,
                                 pild_pkg::ST_DONE, 32'h0, 7'd2));
        plan.push_back(known_row(pild_pkg::ACT_INSERT, 7'd2, 32'h12345678,
                                 pild_pkg::ST_DONE, 32'h0, 7'd3));
        plan.push_back(known_row(pild_pkg::ACT_INSERT, 7'd1, 32'hA5A5A5A5,
                                 pild_pkg::ST_DONE, 32'h0, 7'd4));
        plan.push_back(known_row(pild_pkg::ACT_READ,   7'd3, 32'h0,
                                 pild_pkg::ST_DONE, 32'h12345678, 7'd4));
        plan.push_back(known_row(pild_pkg::ACT_WRITE,  7'd1, 32'h5A5A5A5A,
                                 pild_pkg::ST_DONE, 32'h0, 7'd4));
        plan.push_back(known_row(pild_pkg::ACT_READ,   7'd1, 32'h0,
                                 pild_pkg::ST_DONE, 32'h5A5A5A5A, 7'd4));
        plan.push_back(known_row(pild_pkg::ACT_DELETE, 7'd0, 32'h0,
                                 pild_pkg::ST_DONE, 32'hFFFFFFFF, 7'd3));
        // position at and far past the length, undefined actions
        plan.push_back(known_row(pild_pkg::ACT_READ, 7'd3,   32'h0,
                                 pild_pkg::ST_RANGE, 32'h0, 7'd3));
        plan.push_back(known_row(pild_pkg::ACT_READ, 7'd127, 32'h0,
                                 pild_pkg::ST_RANGE, 32'h0, 7'd3));
        plan.push_back(known_row(ACT_RSVD_LO,  7'd0,   32'h0,
                                 pild_pkg::ST_RANGE, 32'h0, 7'd3));
        plan.push_back(known_row(ACT_RSVD_MID, 7'd127, 32'hFFFFFFFF,
                                 pild_pkg::ST_RANGE, 32'h0, 7'd3));
        plan.push_back(known_row(ACT_RSVD_HI,  7'd1,   32'h0,
                                 pild_pkg::ST_RANGE, 32'h0, 7'd3));
        // fill up, then hit the full list
        plan.push_back(pred_row(pild_pkg::ACT_APPEND, 7'd0, pild_pkg::DEPTH - 3));
        plan.push_back(known_row(pild_pkg::ACT_APPEND, 7'd0,  32'hFFFFFFFF,
                                 pild_pkg::ST_FULL,  32'h0, 7'd64));
        plan.push_back(known_row(pild_pkg::ACT_INSERT, 7'd64, 32'h0,
                                 pild_pkg::ST_FULL,  32'h0, 7'd64));
        plan.push_back(known_row(pild_pkg::ACT_INSERT, 7'd65, 32'h0,
                                 pild_pkg::ST_RANGE, 32'h0, 7'd64));
        plan.push_back(pred_row(pild_pkg::ACT_READ,   7'd63, 1));
        plan.push_back(pred_row(pild_pkg::ACT_DELETE, 7'd63, 1));
        plan.push_back(known_row(pild_pkg::ACT_INSERT, 7'd0, 32'h0,
                                 pild_pkg::ST_DONE, 32'h0, 7'd64));
        // drain from the front down to empty
        plan.push_back(pred_row(pild_pkg::ACT_DELETE, 7'd0, pild_pkg::DEPTH));
        plan.push_back(known_row(pild_pkg::ACT_DELETE, 7'd0, 32'h0,
                                 pild_pkg::ST_RANGE, 32'h0, 7'd0));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (plan[n])
            for (int k = 0; k < plan[n].reps; k++)
                send_cmd(plan[n].act, plan[n].pos,
                         (plan[n].reps > 1) ? $urandom : plan[n].val,
                         plan[n].typed, plan[n].want);

        // random phases: no idling, idle sender, stalling receiver, both
        run_random(PHASE_ITEMS);
        send_idle_pct = 67;
        run_random(PHASE_ITEMS);
        send_idle_pct  = 0;
        recv_stall_pct = 67;
        run_random(PHASE_ITEMS);
        send_idle_pct  = 11;
        recv_stall_pct = 11;
        run_random(PHASE_ITEMS);

        // long response hold-off while commands keep coming
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rsp_hold_left  = HOLD_CYCLES;
        run_random(PHASE_ITEMS);

        cmd_ch.valid <= 1'b0;
        while (awaited_rsp.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (err_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
